### hdl/chs_pkg.sv
`default_nettype none
package chs_pkg;

    localparam int BUCKETS_DEF    = 64;
    localparam int POOL_NODES_DEF = 256;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 10;
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 3;

    // reciprocal precision of the bucket reduction, exact for any key below 2**KEY_W
    localparam int HASH_SHIFT = 2 * KEY_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage
`default_nettype wire

### hdl/chained_hash_key_store.sv
// channel   direction  handshake            word
// request   in         in_valid / in_ready   op, key, handle
// result    out        out_valid / out_ready ok, found_handle, status
//
// one request at a time; after acceptance it passes hash, head read and head states,
// a node state per chain node read, a miss state if the walk ends unmatched,
// and one each for a remove hit or a free-list insert; in_ready rises with out_valid
// after reset the bucket heads are all cleared with in_ready low
// a finished result waits in the output register; the next request is accepted
// meanwhile, and its result waits until that register has been taken
`default_nettype none
module chained_hash_key_store #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [chs_pkg::OP_W-1:0]     op,
    input  wire logic [chs_pkg::KEY_W-1:0]    key,
    input  wire logic [chs_pkg::HANDLE_W-1:0] handle,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             ok,
    output logic      [chs_pkg::HANDLE_W-1:0] found_handle,
    output logic      [chs_pkg::STATUS_W-1:0] status
);
    import chs_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HASH  = 9'b000000010,
        S_HREAD = 9'b000000100,
        S_HEAD  = 9'b000001000,
        S_NODE  = 9'b000010000,
        S_MISS  = 9'b000100000,
        S_POP   = 9'b001000000,
        S_REM   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       prev_reg, prev_next;
    logic [KEY_W-1:0]    prev_key_reg, prev_key_next;
    logic [HANDLE_W-1:0] prev_handle_reg, prev_handle_next;
    logic [KEY_W-1:0]    cur_key_reg, cur_key_next;
    logic [HANDLE_W-1:0] cur_handle_reg, cur_handle_next;
    logic [LW-1:0]       free_head_reg, free_head_next;
    logic [LW-1:0]       alloc_top_reg, alloc_top_next;
    logic                res_ok_reg, res_ok_next;
    logic [HANDLE_W-1:0] res_found_reg, res_found_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic                ok_reg, ok_next;
    logic [HANDLE_W-1:0] found_handle_reg, found_handle_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                accept;
    logic [BW-1:0]       bucket;
    logic                bkt_busy;
    logic                bkt_wr_en;
    logic [LW-1:0]       bkt_wr_data;
    logic                bkt_rd_en;
    logic [LW-1:0]       bkt_rd_data;
    logic                node_wr_en;
    logic [IW-1:0]       node_wr_addr;
    logic [KEY_W-1:0]    node_wr_key;
    logic [HANDLE_W-1:0] node_wr_handle;
    logic [LW-1:0]       node_wr_link;
    logic                node_rd_en;
    logic [IW-1:0]       node_rd_addr;
    logic [KEY_W-1:0]    node_rd_key;
    logic [HANDLE_W-1:0] node_rd_handle;
    logic [LW-1:0]       node_rd_link;

    assign in_ready = (state_reg == S_IDLE) && !bkt_busy;
    assign accept   = in_valid && in_ready;

    chs_hash #(
        .BUCKETS(BUCKETS)
    ) u_hash (
        .clk   (clk),
        .load  (accept),
        .key   (key),
        .bucket(bucket)
    );

    chs_bucket_mem #(
        .BUCKETS   (BUCKETS),
        .POOL_NODES(POOL_NODES)
    ) u_bucket_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (bkt_wr_en),
        .wr_addr(bucket),
        .wr_data(bkt_wr_data),
        .rd_en  (bkt_rd_en),
        .rd_addr(bucket),
        .rd_data(bkt_rd_data),
        .busy   (bkt_busy)
    );

    chs_node_mem #(
        .POOL_NODES(POOL_NODES)
    ) u_node_mem (
        .clk      (clk),
        .wr_en    (node_wr_en),
        .wr_addr  (node_wr_addr),
        .wr_key   (node_wr_key),
        .wr_handle(node_wr_handle),
        .wr_link  (node_wr_link),
        .rd_en    (node_rd_en),
        .rd_addr  (node_rd_addr),
        .rd_key   (node_rd_key),
        .rd_handle(node_rd_handle),
        .rd_link  (node_rd_link)
    );

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        handle_next       = handle_reg;
        head_next         = head_reg;
        cur_next          = cur_reg;
        prev_next         = prev_reg;
        prev_key_next     = prev_key_reg;
        prev_handle_next  = prev_handle_reg;
        cur_key_next      = cur_key_reg;
        cur_handle_next   = cur_handle_reg;
        free_head_next    = free_head_reg;
        alloc_top_next    = alloc_top_reg;
        res_ok_next       = res_ok_reg;
        res_found_next    = res_found_reg;
        res_status_next   = res_status_reg;
        ok_next           = ok_reg;
        found_handle_next = found_handle_reg;
        status_next       = status_reg;
        out_valid_next    = out_valid_reg && !out_ready;

        bkt_wr_en      = 1'b0;
        bkt_wr_data    = cur_reg;
        bkt_rd_en      = 1'b0;
        node_wr_en     = 1'b0;
        node_wr_addr   = cur_reg[IW-1:0];
        node_wr_key    = key_reg;
        node_wr_handle = handle_reg;
        node_wr_link   = head_reg;
        node_rd_en     = 1'b0;
        node_rd_addr   = cur_reg[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op;
                    key_next    = key;
                    handle_next = handle;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                state_next = S_HREAD;
            end
            S_HREAD:
            begin
                bkt_rd_en  = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                head_next      = bkt_rd_data;
                cur_next       = bkt_rd_data;
                prev_next      = NIL;
                res_ok_next    = 1'b0;
                res_found_next = '0;
                if (op_reg == OP_INSERT && handle_reg == '0)
                begin
                    res_status_next = ST_NULL;
                    state_next      = S_DONE;
                end
                else if (op_reg != OP_INSERT && op_reg != OP_SEARCH && op_reg != OP_REMOVE)
                begin
                    res_status_next = ST_DONE;
                    state_next      = S_DONE;
                end
                else if (bkt_rd_data == NIL)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = bkt_rd_data[IW-1:0];
                    state_next   = S_NODE;
                end
            end
            S_NODE:
            begin
                if (node_rd_key == key_reg)
                begin
                    case (op_reg)
                        OP_SEARCH:
                        begin
                            res_ok_next     = 1'b1;
                            res_found_next  = node_rd_handle;
                            res_status_next = ST_DONE;
                            state_next      = S_DONE;
                        end
                        OP_INSERT:
                        begin
                            res_ok_next     = 1'b0;
                            res_found_next  = '0;
                            res_status_next = ST_DUP;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            // unlink from predecessor or bucket head
                            if (prev_reg == NIL)
                            begin
                                bkt_wr_en   = 1'b1;
                                bkt_wr_data = node_rd_link;
                            end
                            else
                            begin
                                node_wr_en     = 1'b1;
                                node_wr_addr   = prev_reg[IW-1:0];
                                node_wr_key    = prev_key_reg;
                                node_wr_handle = prev_handle_reg;
                                node_wr_link   = node_rd_link;
                            end
                            cur_key_next    = node_rd_key;
                            cur_handle_next = node_rd_handle;
                            state_next      = S_REM;
                        end
                    endcase
                end
                else
                begin
                    prev_next        = cur_reg;
                    prev_key_next    = node_rd_key;
                    prev_handle_next = node_rd_handle;
                    cur_next         = node_rd_link;
                    if (node_rd_link == NIL)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        node_rd_en   = 1'b1;
                        node_rd_addr = node_rd_link[IW-1:0];
                        state_next   = S_NODE;
                    end
                end
            end
            S_REM:
            begin
                // push removed node onto the free list
                node_wr_en      = 1'b1;
                node_wr_addr    = cur_reg[IW-1:0];
                node_wr_key     = cur_key_reg;
                node_wr_handle  = cur_handle_reg;
                node_wr_link    = free_head_reg;
                free_head_next  = cur_reg;
                res_ok_next     = 1'b1;
                res_found_next  = '0;
                res_status_next = ST_DONE;
                state_next      = S_DONE;
            end
            S_MISS:
            begin
                res_found_next = '0;
                if (op_reg != OP_INSERT)
                begin
                    res_ok_next     = 1'b0;
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else if (free_head_reg != NIL)
                begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = free_head_reg[IW-1:0];
                    state_next   = S_POP;
                end
                else if (alloc_top_reg != NIL)
                begin
                    node_wr_en      = 1'b1;
                    node_wr_addr    = alloc_top_reg[IW-1:0];
                    node_wr_link    = head_reg;
                    bkt_wr_en       = 1'b1;
                    bkt_wr_data     = alloc_top_reg;
                    alloc_top_next  = alloc_top_reg + LW'(1);
                    res_ok_next     = 1'b1;
                    res_status_next = ST_DONE;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_ok_next     = 1'b0;
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
            end
            S_POP:
            begin
                node_wr_en      = 1'b1;
                node_wr_addr    = free_head_reg[IW-1:0];
                node_wr_link    = head_reg;
                bkt_wr_en       = 1'b1;
                bkt_wr_data     = free_head_reg;
                free_head_next  = node_rd_link;
                res_ok_next     = 1'b1;
                res_found_next  = '0;
                res_status_next = ST_DONE;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ok_next           = res_ok_reg;
                    found_handle_next = res_found_reg;
                    status_next       = res_status_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= NIL;
            alloc_top_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            alloc_top_reg <= alloc_top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        key_reg          <= key_next;
        handle_reg       <= handle_next;
        head_reg         <= head_next;
        cur_reg          <= cur_next;
        prev_reg         <= prev_next;
        prev_key_reg     <= prev_key_next;
        prev_handle_reg  <= prev_handle_next;
        cur_key_reg      <= cur_key_next;
        cur_handle_reg   <= cur_handle_next;
        res_ok_reg       <= res_ok_next;
        res_found_reg    <= res_found_next;
        res_status_reg   <= res_status_next;
        ok_reg           <= ok_next;
        found_handle_reg <= found_handle_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign found_handle = found_handle_reg;
    assign status       = status_reg;

`ifndef NO_ASSERTIONS
    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NIL)
        else $error("free list head out of range");

    a_alloc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> alloc_top_reg >= $past(alloc_top_reg))
        else $error("allocation count went down");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ok_reg |-> status_reg == ST_DONE)
        else $error("success word with error status");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_handle_reg != '0 |-> ok_reg)
        else $error("handle returned without a hit");
`endif

endmodule
`default_nettype wire

### hdl/chs_hash.sv
`default_nettype none
module chs_hash #(
    parameter int BUCKETS = chs_pkg::BUCKETS_DEF,
    localparam int BW = $clog2(BUCKETS)
) (
    input  wire logic                     clk,
    input  wire logic                     load,
    input  wire logic [chs_pkg::KEY_W-1:0] key,
    output logic      [BW-1:0]            bucket
);
    import chs_pkg::*;

    localparam int RW  = HASH_SHIFT + 1;
    localparam int PW  = KEY_W + RW;
    localparam int P2W = 2 * KEY_W + 1;
    localparam logic [RW-1:0]    RECIP     = RW'(((1 << HASH_SHIFT) + BUCKETS - 1) / BUCKETS);
    localparam logic [KEY_W:0]   BUCKETS_C = (KEY_W + 1)'(BUCKETS);

    logic [PW-1:0]    prod_reg;
    logic [KEY_W-1:0] key_d_reg;
    logic [KEY_W-1:0] quot;
    logic [P2W-1:0]   back_prod;
    logic [KEY_W-1:0] remain;
    logic [BW-1:0]    bucket_reg;

    // stage one: quotient estimate by reciprocal
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg  <= {{RW{1'b0}}, key} * {{KEY_W{1'b0}}, RECIP};
            key_d_reg <= key;
        end
    end

    assign quot      = prod_reg[HASH_SHIFT +: KEY_W];
    assign back_prod = {{(KEY_W + 1){1'b0}}, quot} * {{KEY_W{1'b0}}, BUCKETS_C};
    assign remain    = key_d_reg - back_prod[KEY_W-1:0];

    // stage two: remainder
    always_ff @(posedge clk)
    begin
        bucket_reg <= remain[BW-1:0];
    end

    assign bucket = bucket_reg;

endmodule
`default_nettype wire

### hdl/chs_bucket_mem.sv
`default_nettype none
module chs_bucket_mem #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
    localparam int BW = $clog2(BUCKETS),
    localparam int LW = $clog2(POOL_NODES + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [BW-1:0] wr_addr,
    input  wire logic [LW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [BW-1:0] rd_addr,
    output logic      [LW-1:0] rd_data,
    output logic               busy
);
    import chs_pkg::*;

    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    logic [LW-1:0] mem [BUCKETS];
    logic [LW-1:0] rd_data_reg;
    logic          clr_active_reg;
    logic [BW-1:0] clr_cnt_reg;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_cnt_reg == BW'(BUCKETS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + BW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_cnt_reg] <= NIL;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule
`default_nettype wire

### hdl/chs_node_mem.sv
`default_nettype none
module chs_node_mem #(
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
    localparam int IW = $clog2(POOL_NODES),
    localparam int LW = $clog2(POOL_NODES + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [IW-1:0]               wr_addr,
    input  wire logic [chs_pkg::KEY_W-1:0]    wr_key,
    input  wire logic [chs_pkg::HANDLE_W-1:0] wr_handle,
    input  wire logic [LW-1:0]               wr_link,
    input  wire logic                        rd_en,
    input  wire logic [IW-1:0]               rd_addr,
    output logic      [chs_pkg::KEY_W-1:0]    rd_key,
    output logic      [chs_pkg::HANDLE_W-1:0] rd_handle,
    output logic      [LW-1:0]               rd_link
);
    import chs_pkg::*;

    localparam int WW = KEY_W + HANDLE_W + LW;

    logic [WW-1:0] mem [POOL_NODES];
    logic [WW-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_handle, wr_link};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_key    = rd_word_reg[WW-1 -: KEY_W];
    assign rd_handle = rd_word_reg[LW +: HANDLE_W];
    assign rd_link   = rd_word_reg[LW-1:0];

endmodule
`default_nettype wire
